@@ rtl/core/crsf_channel_frame_encoder_core_assert.svh @@
// Assertion macros shared by the encoder modules.
`ifndef CRSF_CHANNEL_FRAME_ENCODER_CORE_ASSERT_SVH
`define CRSF_CHANNEL_FRAME_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define CFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/cfe_pkg.sv @@
`default_nettype none
package cfe_pkg;

    localparam int CHANNEL_COUNT_DEF  = 16;
    localparam int MAX_TELE_BYTES_DEF = 64;

    localparam int          CH_BITS    = 11;
    localparam logic [7:0]  ADDR_BYTE  = 8'hEE;
    localparam logic [7:0]  CH_TYPE    = 8'h16;
    localparam logic [7:0]  CRC_POLY   = 8'hD5;
    localparam logic [10:0] CH_CENTER  = 11'd992;
    localparam logic [10:0] CH_MAX     = 11'd1984;
    localparam logic [15:0] CH_SAT_MAG = 16'd1240;
    localparam logic [16:0] DIV5_RECIP = 17'd52429;
    localparam int          DIV5_SHIFT = 18;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        OP_CHANNEL = 1'b0,
        OP_TELE    = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_LEN,
        S_HEAD,
        S_DATA,
        S_PAD,
        S_CRC
    } t_back_state;

    typedef struct packed {
        t_opcode     kind;
        logic        open;
        logic        last;
        logic [10:0] chan_val;
        logic [7:0]  data;
        logic [7:0]  command;
        logic [6:0]  count;
    } t_cmd;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/cfe_front.sv @@
`default_nettype none
module cfe_front #(
    parameter int CHANNEL_COUNT  = cfe_pkg::CHANNEL_COUNT_DEF,
    parameter int MAX_TELE_BYTES = cfe_pkg::MAX_TELE_BYTES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [39:0]   i_data,
    input  wire logic          i_user,
    input  wire logic          i_q_full,
    output logic               o_push,
    output cfe_pkg::t_cmd      o_cmd
);

    localparam int SLOTS = (CHANNEL_COUNT < 2) ? 2 : CHANNEL_COUNT;

    logic               r_in_frame, n_in_frame;
    cfe_pkg::t_opcode   r_kind, n_kind;
    logic [6:0]         r_left, n_left;

    cfe_pkg::t_opcode   op;
    logic signed [15:0] v;
    logic [15:0]        mag;
    logic [12:0]        quad;
    logic [29:0]        prod;
    logic [10:0]        quot;
    logic [10:0]        scaled;
    logic [6:0]         cnt;
    logic [6:0]         left_base;
    logic [6:0]         left_new;
    logic               take;

    always_comb begin
        op   = cfe_pkg::t_opcode'(i_user);
        v    = $signed(i_data[15:0]);
        cnt  = i_data[38:32];
        mag  = v[15] ? 16'(-v) : 16'(v);
        quad = {mag[10:0], 2'b00};
        prod = 30'(quad) * 30'(cfe_pkg::DIV5_RECIP);
        quot = 11'(prod[29:cfe_pkg::DIV5_SHIFT]);
        if (mag >= cfe_pkg::CH_SAT_MAG) begin
            scaled = v[15] ? 11'd0 : cfe_pkg::CH_MAX;
        end else begin
            scaled = v[15] ? (cfe_pkg::CH_CENTER - quot) : (cfe_pkg::CH_CENTER + quot);
        end
    end

    always_comb begin
        o_ready    = !i_q_full;
        take       = i_valid && o_ready;
        n_in_frame = r_in_frame;
        n_kind     = r_kind;
        n_left     = r_left;
        o_push     = 1'b0;
        left_base  = r_in_frame ? r_left : 7'(SLOTS);
        if (op == cfe_pkg::OP_TELE && !r_in_frame) begin
            left_base = cnt;
        end
        left_new = left_base - 7'd1;

        o_cmd.kind     = op;
        o_cmd.open     = !r_in_frame;
        o_cmd.last     = (left_new == 7'd0);
        o_cmd.chan_val = scaled;
        o_cmd.data     = i_data[23:16];
        o_cmd.command  = i_data[31:24];
        o_cmd.count    = cnt;

        if (take) begin
            if (r_in_frame && op != r_kind) begin
                o_push = 1'b0;
            end else if (op == cfe_pkg::OP_TELE && !r_in_frame &&
                         (cnt == 7'd0 || cnt > 7'(MAX_TELE_BYTES))) begin
                o_push = 1'b0;
            end else begin
                o_push     = 1'b1;
                n_in_frame = (left_new != 7'd0);
                n_kind     = op;
                n_left     = left_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_kind     <= cfe_pkg::OP_CHANNEL;
            r_left     <= 7'd0;
        end else begin
            r_in_frame <= n_in_frame;
            r_kind     <= n_kind;
            r_left     <= n_left;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/cfe_queue.sv @@
`default_nettype none
`include "crsf_channel_frame_encoder_core_assert.svh"
module cfe_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire cfe_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output cfe_pkg::t_cmd      o_cmd,
    output logic               o_full,
    output logic               o_empty
);

    cfe_pkg::t_cmd                r_mem [cfe_pkg::QUEUE_DEPTH];
    logic [cfe_pkg::QPTR_W-1:0]   r_wr, n_wr;
    logic [cfe_pkg::QPTR_W-1:0]   r_rd, n_rd;
    logic [cfe_pkg::QPTR_W:0]     r_cnt, n_cnt;
    logic                         do_push;
    logic                         do_pop;

    always_comb begin
        o_full  = (r_cnt == (cfe_pkg::QPTR_W+1)'(cfe_pkg::QUEUE_DEPTH));
        o_empty = (r_cnt == '0);
        o_cmd   = r_mem[r_rd];
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        n_wr    = do_push ? r_wr + 1'b1 : r_wr;
        n_rd    = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt   = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    `CFE_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, o_full, !i_push, "push into full queue")

endmodule
`default_nettype wire

@@ rtl/core/cfe_back.sv @@
`default_nettype none
`include "crsf_channel_frame_encoder_core_assert.svh"
module cfe_back #(
    parameter int CHANNEL_COUNT = cfe_pkg::CHANNEL_COUNT_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire cfe_pkg::t_cmd i_cmd,
    input  wire logic          i_q_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [7:0]         o_byte,
    output logic               o_end,
    output logic [6:0]         o_len
);

    localparam int SLOTS      = (CHANNEL_COUNT < 2) ? 2 : CHANNEL_COUNT;
    localparam int CH_PAYLOAD = (SLOTS * cfe_pkg::CH_BITS + 7) / 8;
    localparam logic [7:0] CH_LEN_BYTE = 8'(CH_PAYLOAD + 2);

    cfe_pkg::t_back_state r_state, n_state;
    cfe_pkg::t_cmd        r_cmd, n_cmd;
    logic [17:0]          r_acc, n_acc;
    logic [4:0]           r_bits, n_bits;
    logic [7:0]           r_crc, n_crc;
    logic [6:0]           r_sent, n_sent;
    logic                 r_out_valid, n_out_valid;
    logic [7:0]           r_out_byte, n_out_byte;
    logic                 r_out_end, n_out_end;
    logic [6:0]           r_out_len, n_out_len;

    logic                 adv;
    logic                 emit;
    logic                 in_crc;
    logic                 done;
    logic [7:0]           byte_q;
    logic                 end_q;
    logic [6:0]           len_q;

    logic                 chan_step;
    logic                 close_out;
    logic                 crc_step;
    logic                 cleared;

    always_comb begin
        adv         = !r_out_valid || i_ready;
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_acc       = r_acc;
        n_bits      = r_bits;
        n_crc       = r_crc;
        n_sent      = r_sent;
        emit        = 1'b0;
        in_crc      = 1'b0;
        done        = 1'b0;
        byte_q      = 8'd0;
        end_q       = 1'b0;
        len_q       = 7'd0;
        o_pop       = 1'b0;

        case (r_state)
            cfe_pkg::S_IDLE: begin
                done = 1'b1;
            end
            cfe_pkg::S_ADDR: begin
                if (adv) begin
                    emit    = 1'b1;
                    byte_q  = cfe_pkg::ADDR_BYTE;
                    n_state = cfe_pkg::S_LEN;
                end
            end
            cfe_pkg::S_LEN: begin
                if (adv) begin
                    emit    = 1'b1;
                    byte_q  = (r_cmd.kind == cfe_pkg::OP_TELE) ?
                              ({1'b0, r_cmd.count} + 8'd2) : CH_LEN_BYTE;
                    n_state = cfe_pkg::S_HEAD;
                end
            end
            cfe_pkg::S_HEAD: begin
                if (adv) begin
                    emit    = 1'b1;
                    in_crc  = 1'b1;
                    byte_q  = (r_cmd.kind == cfe_pkg::OP_TELE) ? r_cmd.command
                                                               : cfe_pkg::CH_TYPE;
                    n_state = cfe_pkg::S_DATA;
                end
            end
            cfe_pkg::S_DATA: begin
                if (adv) begin
                    emit   = 1'b1;
                    in_crc = 1'b1;
                    if (r_cmd.kind == cfe_pkg::OP_TELE) begin
                        byte_q = r_cmd.data;
                        if (r_cmd.last) begin
                            n_state = cfe_pkg::S_CRC;
                        end else begin
                            done = 1'b1;
                        end
                    end else begin
                        byte_q = r_acc[7:0];
                        n_acc  = r_acc >> 8;
                        n_bits = r_bits - 5'd8;
                        if (r_bits < 5'd16) begin
                            if (r_cmd.last) begin
                                n_state = (n_bits != 5'd0) ? cfe_pkg::S_PAD : cfe_pkg::S_CRC;
                            end else begin
                                done = 1'b1;
                            end
                        end
                    end
                end
            end
            cfe_pkg::S_PAD: begin
                if (adv) begin
                    emit    = 1'b1;
                    in_crc  = 1'b1;
                    byte_q  = r_acc[7:0];
                    n_acc   = '0;
                    n_bits  = '0;
                    n_state = cfe_pkg::S_CRC;
                end
            end
            cfe_pkg::S_CRC: begin
                if (adv) begin
                    emit   = 1'b1;
                    byte_q = r_crc;
                    end_q  = 1'b1;
                    len_q  = r_sent + 7'd1;
                    n_acc  = '0;
                    n_bits = '0;
                    done   = 1'b1;
                end
            end
            default: begin
                n_state = cfe_pkg::S_IDLE;
            end
        endcase

        if (emit) begin
            n_sent = r_sent + 7'd1;
            if (in_crc) begin
                n_crc = cfe_pkg::crc8_update(r_crc, byte_q);
            end
        end
        if (end_q) begin
            n_sent = '0;
            n_crc  = '0;
        end

        if (done) begin
            if (!i_q_empty) begin
                o_pop   = 1'b1;
                n_cmd   = i_cmd;
                n_state = i_cmd.open ? cfe_pkg::S_ADDR : cfe_pkg::S_DATA;
                if (i_cmd.kind == cfe_pkg::OP_CHANNEL) begin
                    n_acc  = n_acc | (18'(i_cmd.chan_val) << n_bits[2:0]);
                    n_bits = n_bits + 5'(cfe_pkg::CH_BITS);
                end
            end else begin
                n_state = cfe_pkg::S_IDLE;
            end
        end

        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_end   = r_out_end;
        n_out_len   = r_out_len;
        if (adv) begin
            n_out_valid = emit;
            n_out_byte  = byte_q;
            n_out_end   = end_q;
            n_out_len   = len_q;
        end

        o_valid = r_out_valid;
        o_byte  = r_out_byte;
        o_end   = r_out_end;
        o_len   = r_out_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cfe_pkg::S_IDLE;
            r_acc       <= '0;
            r_bits      <= '0;
            r_crc       <= '0;
            r_sent      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_bits      <= n_bits;
            r_crc       <= n_crc;
            r_sent      <= n_sent;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_out_byte <= n_out_byte;
        r_out_end  <= n_out_end;
        r_out_len  <= n_out_len;
    end

    always_comb begin
        chan_step = (r_state == cfe_pkg::S_DATA) && (r_cmd.kind == cfe_pkg::OP_CHANNEL);
        close_out = r_out_valid && r_out_end;
        crc_step  = (r_state == cfe_pkg::S_CRC) && adv;
        cleared   = (r_sent == 7'd0) && (r_crc == 8'd0) && (r_bits < 5'd19);
    end

    `CFE_ASSERT_IMP(a_chan_bits, i_clk, i_rst_n, chan_step, r_bits >= 5'd8, "short channel step")
    `CFE_ASSERT_IMP(a_end_len, i_clk, i_rst_n, close_out, r_out_len >= 7'd5, "short frame")
    `CFE_ASSERT_NXT(a_crc_clear, i_clk, i_rst_n, crc_step, cleared, "state not cleared")

endmodule
`default_nettype wire

@@ rtl/core/crsf_channel_frame_encoder_core.sv @@
`default_nettype none
// Frame encoder for a serial radio-control link. Requests enter on the slave stream: tuser
// picks a channel value or a telemetry data byte, and the first request of a frame opens a
// frame of that kind. A front stage classifies each request, scales channel values to
// 11 bits and drops refused or mismatched requests; it takes one request per clock while
// its four-entry queue has room. A back stage turns each queued request into frame bytes
// at one byte per clock while the sink is ready, through a registered output: a mid-frame
// channel request yields one or two bytes, a telemetry byte one, and the requests that
// open or close a frame up to five (header, data, pad, CRC-8). Sustained request rate is
// thus set by the single byte emitter.
module crsf_channel_frame_encoder_core #(
    parameter int CHANNEL_COUNT  = cfe_pkg::CHANNEL_COUNT_DEF,
    parameter int MAX_TELE_BYTES = cfe_pkg::MAX_TELE_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // channel_value[15:0], tele_byte[23:16], tele_command[31:24], tele_count[38:32]
    input  wire logic [39:0] i_s_axis_tdata,
    // opcode[0]
    input  wire logic        i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // out_byte[7:0], frame_length[14:8]
    output logic [15:0]      o_m_axis_tdata,
    output logic             o_m_axis_tlast
);

    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;
    cfe_pkg::t_cmd  front_cmd;
    cfe_pkg::t_cmd  head_cmd;
    logic [7:0]     out_byte;
    logic [6:0]     out_len;

    cfe_front #(
        .CHANNEL_COUNT  (CHANNEL_COUNT),
        .MAX_TELE_BYTES (MAX_TELE_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_data   (i_s_axis_tdata),
        .i_user   (i_s_axis_tuser),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    cfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    cfe_back #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (head_cmd),
        .i_q_empty (q_empty),
        .o_pop     (pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_byte    (out_byte),
        .o_end     (o_m_axis_tlast),
        .o_len     (out_len)
    );

    assign o_m_axis_tdata = {1'b0, out_len, out_byte};

endmodule
`default_nettype wire
